### rtl/block_partition_owner_map_3d_top_defines.svh
// Assertion macros for the block partition owner map.
// Included by the top level; depends on nothing else.
`ifndef BLOCK_PARTITION_OWNER_MAP_3D_TOP_DEFINES_SVH
`define BLOCK_PARTITION_OWNER_MAP_3D_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define BPOM3D_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define BPOM3D_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/bpom3d_pkg.sv
// Shared constants and types for the block partition owner map.
// No dependencies.
package bpom3d_pkg;

   // Default widths of the task and processor dimensions
   localparam int unsigned TASK_DIM_BITS_DEF = 16;
   localparam int unsigned PROC_DIM_BITS_DEF = 10;

   // Fixed width of the linear task index
   localparam int unsigned IDX_W = 48;

   // Register index port width
   localparam int unsigned CSR_ADDR_W = 3;

   // Register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_TASK_DIM_X = 3'd0,
      REG_TASK_DIM_Y = 3'd1,
      REG_TASK_DIM_Z = 3'd2,
      REG_PROC_DIM_X = 3'd3,
      REG_PROC_DIM_Y = 3'd4,
      REG_PROC_DIM_Z = 3'd5
   } csr_reg_type;

   // Sequencer states, one-hot
   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_DIV_X  = 9'b000000010,
      ST_DIV_Y  = 9'b000000100,
      ST_B_LOAD = 9'b000001000,
      ST_MUL_B  = 9'b000010000,
      ST_DIV_B  = 9'b000100000,
      ST_MUL_T  = 9'b001000000,
      ST_MUL_R  = 9'b010000000,
      ST_DONE   = 9'b100000000
   } state_type;

endpackage

### rtl/block_partition_owner_map_3d_top.sv
// Block partition owner map: linear task index to owning processor rank.
// Depends on bpom3d_pkg and block_partition_owner_map_3d_top_defines.svh.
//
// One item is worked at a time, using a shared restoring divider that retires one
// quotient bit per cycle and a shared shift-add multiplier that retires one
// multiplier bit per cycle. The index is divided by the x and y task extents to
// get the task coordinates, and the index is in range when the final quotient is
// below the z extent. Each axis block is ((c+1)*P - 1) / N, and the rank is
// px*(py*bz + by) + bx. When a task extent is zero the sequencer goes from the
// accept straight to the done state. An index beyond the grid skips the block
// search and the rank multiply. A result waits in an output register, so the next
// item may be accepted while the previous result is still pending.
`include "block_partition_owner_map_3d_top_defines.svh"

module block_partition_owner_map_3d_top #(
   parameter int unsigned TASK_DIM_BITS = bpom3d_pkg::TASK_DIM_BITS_DEF,
   parameter int unsigned PROC_DIM_BITS = bpom3d_pkg::PROC_DIM_BITS_DEF,
   parameter int unsigned CSR_W = (TASK_DIM_BITS > PROC_DIM_BITS + 1) ?
                                  TASK_DIM_BITS : PROC_DIM_BITS + 1
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration write port
   input  logic                              csr_we,
   input  logic [bpom3d_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_W-1:0]                  csr_wdata,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [bpom3d_pkg::IDX_W-1:0]      req_task_index,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [3*PROC_DIM_BITS-1:0]        rsp_owner_rank,
   output logic [PROC_DIM_BITS-1:0]          rsp_block_x,
   output logic [PROC_DIM_BITS-1:0]          rsp_block_y,
   output logic [PROC_DIM_BITS-1:0]          rsp_block_z,
   output logic                              rsp_index_in_range
);
   import bpom3d_pkg::*;

   localparam int unsigned T      = TASK_DIM_BITS;
   localparam int unsigned P      = PROC_DIM_BITS;
   localparam int unsigned DIVB_W = T + P + 1;
   localparam int unsigned MUL_W  = (DIVB_W > 3 * P) ? DIVB_W : 3 * P;
   localparam int unsigned DCNT_W = $clog2(IDX_W + 1);
   localparam int unsigned MCNT_W = $clog2(P + 2);

   // Clamp a processor extent to the range 1 .. 2**P
   function automatic logic [P:0] proc_eff(input logic [P:0] v);
      logic [P:0] r;
      r = v;
      if (v == '0) begin
         r = {{P{1'b0}}, 1'b1};
      end else if (v[P] && (v[P-1:0] != '0)) begin
         r = {1'b1, {P{1'b0}}};
      end
      return r;
   endfunction

   // Configuration registers
   logic [T-1:0] tdim_x_ff, tdim_x_in, tdim_y_ff, tdim_y_in, tdim_z_ff, tdim_z_in;
   logic [P:0]   pdim_x_ff, pdim_x_in, pdim_y_ff, pdim_y_in, pdim_z_ff, pdim_z_in;

   // Sequencer
   state_type    state_ff, state_in;
   logic [1:0]   ax_ff, ax_in;
   logic         in_range_ff, in_range_in;

   // Divider datapath
   logic [IDX_W-1:0]  div_num_ff, div_num_in;
   logic [T-1:0]      div_rem_ff, div_rem_in;
   logic [T-1:0]      div_den_ff, div_den_in;
   logic [DCNT_W-1:0] div_cnt_ff, div_cnt_in;

   // Multiplier datapath
   logic [MUL_W-1:0]  mul_acc_ff, mul_acc_in;
   logic [MUL_W-1:0]  mul_mcand_ff, mul_mcand_in;
   logic [P:0]        mul_mplier_ff, mul_mplier_in;
   logic [MCNT_W-1:0] mul_cnt_ff, mul_cnt_in;

   // Task coordinates and block coordinates
   logic [T-1:0] coord_x_ff, coord_x_in, coord_y_ff, coord_y_in, coord_z_ff, coord_z_in;
   logic [P-1:0] blk_x_ff, blk_x_in, blk_y_ff, blk_y_in, blk_z_ff, blk_z_in;

   // Output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [3*P-1:0]     rsp_rank_ff, rsp_rank_in;
   logic [P-1:0]       rsp_bx_ff, rsp_bx_in, rsp_by_ff, rsp_by_in, rsp_bz_ff, rsp_bz_in;
   logic               rsp_in_range_ff, rsp_in_range_in;

   // Step logic
   logic [P:0]       pe_x, pe_y, pe_z;
   logic [T:0]       div_shift, div_diff;
   logic             div_ge;
   logic [T-1:0]     div_rem_step;
   logic [IDX_W-1:0] div_num_step;
   logic [MUL_W-1:0] mul_acc_step;
   logic [T-1:0]     sel_coord, sel_tdim;
   logic [P:0]       sel_pe;
   logic             dims_zero;
   logic             out_free;

   assign pe_x = proc_eff(pdim_x_ff);
   assign pe_y = proc_eff(pdim_y_ff);
   assign pe_z = proc_eff(pdim_z_ff);

   // One restoring division step: one quotient bit per cycle
   assign div_shift    = {div_rem_ff, div_num_ff[IDX_W-1]};
   assign div_ge       = div_shift >= {1'b0, div_den_ff};
   assign div_diff     = div_shift - {1'b0, div_den_ff};
   assign div_rem_step = div_ge ? div_diff[T-1:0] : div_shift[T-1:0];
   assign div_num_step = {div_num_ff[IDX_W-2:0], div_ge};

   // One shift-add multiply step: one multiplier bit per cycle
   assign mul_acc_step = mul_mplier_ff[0] ? (mul_acc_ff + mul_mcand_ff) : mul_acc_ff;

   assign dims_zero = (tdim_x_ff == '0) || (tdim_y_ff == '0) || (tdim_z_ff == '0);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Pick the operands of the axis being mapped
   always_comb begin
      case (ax_ff)
         2'd0: begin
            sel_coord = coord_x_ff;
            sel_tdim  = tdim_x_ff;
            sel_pe    = pe_x;
         end
         2'd1: begin
            sel_coord = coord_y_ff;
            sel_tdim  = tdim_y_ff;
            sel_pe    = pe_y;
         end
         default: begin
            sel_coord = coord_z_ff;
            sel_tdim  = tdim_z_ff;
            sel_pe    = pe_z;
         end
      endcase
   end

   // Configuration writes
   always_comb begin
      tdim_x_in = tdim_x_ff;
      tdim_y_in = tdim_y_ff;
      tdim_z_in = tdim_z_ff;
      pdim_x_in = pdim_x_ff;
      pdim_y_in = pdim_y_ff;
      pdim_z_in = pdim_z_ff;
      if (csr_we) begin
         unique case (csr_addr)
            REG_TASK_DIM_X: tdim_x_in = csr_wdata[T-1:0];
            REG_TASK_DIM_Y: tdim_y_in = csr_wdata[T-1:0];
            REG_TASK_DIM_Z: tdim_z_in = csr_wdata[T-1:0];
            REG_PROC_DIM_X: pdim_x_in = csr_wdata[P:0];
            REG_PROC_DIM_Y: pdim_y_in = csr_wdata[P:0];
            REG_PROC_DIM_Z: pdim_z_in = csr_wdata[P:0];
            default: ;
         endcase
      end
   end

   // Sequencer and datapath
   always_comb begin
      state_in        = state_ff;
      ax_in           = ax_ff;
      in_range_in     = in_range_ff;
      div_num_in      = div_num_ff;
      div_rem_in      = div_rem_ff;
      div_den_in      = div_den_ff;
      div_cnt_in      = div_cnt_ff;
      mul_acc_in      = mul_acc_ff;
      mul_mcand_in    = mul_mcand_ff;
      mul_mplier_in   = mul_mplier_ff;
      mul_cnt_in      = mul_cnt_ff;
      coord_x_in      = coord_x_ff;
      coord_y_in      = coord_y_ff;
      coord_z_in      = coord_z_ff;
      blk_x_in        = blk_x_ff;
      blk_y_in        = blk_y_ff;
      blk_z_in        = blk_z_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_rank_in     = rsp_rank_ff;
      rsp_bx_in       = rsp_bx_ff;
      rsp_by_in       = rsp_by_ff;
      rsp_bz_in       = rsp_bz_ff;
      rsp_in_range_in = rsp_in_range_ff;

      unique case (state_ff)
         ST_IDLE: begin
            // Take a transfer and start dividing by the x extent, or go to done if a task extent is zero
            if (req_valid) begin
               div_num_in  = req_task_index;
               div_rem_in  = '0;
               div_den_in  = tdim_x_ff;
               div_cnt_in  = DCNT_W'(IDX_W);
               in_range_in = 1'b0;
               state_in    = dims_zero ? ST_DONE : ST_DIV_X;
            end
         end
         ST_DIV_X: begin
            if (div_cnt_ff != '0) begin
               div_num_in = div_num_step;
               div_rem_in = div_rem_step;
               div_cnt_in = div_cnt_ff - DCNT_W'(1);
            end else begin
               // Remainder is x; divide the quotient by the y extent
               coord_x_in = div_rem_ff;
               div_rem_in = '0;
               div_den_in = tdim_y_ff;
               div_cnt_in = DCNT_W'(IDX_W);
               state_in   = ST_DIV_Y;
            end
         end
         ST_DIV_Y: begin
            if (div_cnt_ff != '0) begin
               div_num_in = div_num_step;
               div_rem_in = div_rem_step;
               div_cnt_in = div_cnt_ff - DCNT_W'(1);
            end else begin
               // Remainder is y, quotient is z; in range when z is below its extent
               coord_y_in  = div_rem_ff;
               coord_z_in  = div_num_ff[T-1:0];
               in_range_in = div_num_ff < {{(IDX_W-T){1'b0}}, tdim_z_ff};
               ax_in       = 2'd0;
               state_in    = (div_num_ff < {{(IDX_W-T){1'b0}}, tdim_z_ff}) ?
                             ST_B_LOAD : ST_DONE;
            end
         end
         ST_B_LOAD: begin
            // Form (c+1)*P - 1 for the current axis
            mul_acc_in    = '1;
            mul_mcand_in  = {{(MUL_W-T){1'b0}}, sel_coord} + {{(MUL_W-1){1'b0}}, 1'b1};
            mul_mplier_in = sel_pe;
            mul_cnt_in    = MCNT_W'(P + 1);
            state_in      = ST_MUL_B;
         end
         ST_MUL_B: begin
            if (mul_cnt_ff != '0) begin
               mul_acc_in    = mul_acc_step;
               mul_mcand_in  = {mul_mcand_ff[MUL_W-2:0], 1'b0};
               mul_mplier_in = {1'b0, mul_mplier_ff[P:1]};
               mul_cnt_in    = mul_cnt_ff - MCNT_W'(1);
            end else begin
               // Align the product to the top of the dividend and divide by N
               div_num_in = {mul_acc_ff[DIVB_W-1:0], {(IDX_W-DIVB_W){1'b0}}};
               div_rem_in = '0;
               div_den_in = sel_tdim;
               div_cnt_in = DCNT_W'(DIVB_W);
               state_in   = ST_DIV_B;
            end
         end
         ST_DIV_B: begin
            if (div_cnt_ff != '0) begin
               div_num_in = div_num_step;
               div_rem_in = div_rem_step;
               div_cnt_in = div_cnt_ff - DCNT_W'(1);
            end else begin
               case (ax_ff)
                  2'd0:    blk_x_in = div_num_ff[P-1:0];
                  2'd1:    blk_y_in = div_num_ff[P-1:0];
                  default: blk_z_in = div_num_ff[P-1:0];
               endcase
               if (ax_ff == 2'd2) begin
                  // Start py*bz + by
                  mul_acc_in    = {{(MUL_W-P){1'b0}}, blk_y_ff};
                  mul_mcand_in  = {{(MUL_W-P){1'b0}}, div_num_ff[P-1:0]};
                  mul_mplier_in = pe_y;
                  mul_cnt_in    = MCNT_W'(P + 1);
                  state_in      = ST_MUL_T;
               end else begin
                  ax_in    = ax_ff + 2'd1;
                  state_in = ST_B_LOAD;
               end
            end
         end
         ST_MUL_T: begin
            if (mul_cnt_ff != '0) begin
               mul_acc_in    = mul_acc_step;
               mul_mcand_in  = {mul_mcand_ff[MUL_W-2:0], 1'b0};
               mul_mplier_in = {1'b0, mul_mplier_ff[P:1]};
               mul_cnt_in    = mul_cnt_ff - MCNT_W'(1);
            end else begin
               // Start px*(py*bz + by) + bx
               mul_acc_in    = {{(MUL_W-P){1'b0}}, blk_x_ff};
               mul_mcand_in  = mul_acc_ff;
               mul_mplier_in = pe_x;
               mul_cnt_in    = MCNT_W'(P + 1);
               state_in      = ST_MUL_R;
            end
         end
         ST_MUL_R: begin
            if (mul_cnt_ff != '0) begin
               mul_acc_in    = mul_acc_step;
               mul_mcand_in  = {mul_mcand_ff[MUL_W-2:0], 1'b0};
               mul_mplier_in = {1'b0, mul_mplier_ff[P:1]};
               mul_cnt_in    = mul_cnt_ff - MCNT_W'(1);
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hold until the output register is free, then load it
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_in_range_in = in_range_ff;
               rsp_rank_in     = in_range_ff ? mul_acc_ff[3*P-1:0] : '0;
               rsp_bx_in       = in_range_ff ? blk_x_ff : '0;
               rsp_by_in       = in_range_ff ? blk_y_ff : '0;
               rsp_bz_in       = in_range_ff ? blk_z_ff : '0;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         tdim_x_ff    <= {{(T-1){1'b0}}, 1'b1};
         tdim_y_ff    <= {{(T-1){1'b0}}, 1'b1};
         tdim_z_ff    <= {{(T-1){1'b0}}, 1'b1};
         pdim_x_ff    <= {{P{1'b0}}, 1'b1};
         pdim_y_ff    <= {{P{1'b0}}, 1'b1};
         pdim_z_ff    <= {{P{1'b0}}, 1'b1};
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         tdim_x_ff    <= tdim_x_in;
         tdim_y_ff    <= tdim_y_in;
         tdim_z_ff    <= tdim_z_in;
         pdim_x_ff    <= pdim_x_in;
         pdim_y_ff    <= pdim_y_in;
         pdim_z_ff    <= pdim_z_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ax_ff           <= ax_in;
      in_range_ff     <= in_range_in;
      div_num_ff      <= div_num_in;
      div_rem_ff      <= div_rem_in;
      div_den_ff      <= div_den_in;
      div_cnt_ff      <= div_cnt_in;
      mul_acc_ff      <= mul_acc_in;
      mul_mcand_ff    <= mul_mcand_in;
      mul_mplier_ff   <= mul_mplier_in;
      mul_cnt_ff      <= mul_cnt_in;
      coord_x_ff      <= coord_x_in;
      coord_y_ff      <= coord_y_in;
      coord_z_ff      <= coord_z_in;
      blk_x_ff        <= blk_x_in;
      blk_y_ff        <= blk_y_in;
      blk_z_ff        <= blk_z_in;
      rsp_rank_ff     <= rsp_rank_in;
      rsp_bx_ff       <= rsp_bx_in;
      rsp_by_ff       <= rsp_by_in;
      rsp_bz_ff       <= rsp_bz_in;
      rsp_in_range_ff <= rsp_in_range_in;
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_owner_rank     = rsp_rank_ff;
   assign rsp_block_x        = rsp_bx_ff;
   assign rsp_block_y        = rsp_by_ff;
   assign rsp_block_z        = rsp_bz_ff;
   assign rsp_index_in_range = rsp_in_range_ff;

   // Checks
   `BPOM3D_ASSERT_IMP(a_out_of_range_zero, clock, reset,
      rsp_valid && !rsp_index_in_range,
      (rsp_owner_rank == '0) && (rsp_block_x == '0) && (rsp_block_y == '0) &&
      (rsp_block_z == '0),
      "out-of-range result carries nonzero fields")
   `BPOM3D_ASSERT_NEXT(a_accept_starts, clock, reset,
      req_valid && req_ready, state_ff != ST_IDLE,
      "accepted transfer did not start the sequencer")
   `BPOM3D_ASSERT_NEXT(a_done_loads, clock, reset,
      (state_ff == ST_DONE) && out_free, rsp_valid_ff && (state_ff == ST_IDLE),
      "finished result not loaded into output register")

endmodule
